@@ src/two_byte_word_replacer_macros.svh @@
// Assertion helpers for the checker file.
`ifndef TWO_BYTE_WORD_REPLACER_MACROS_SVH
`define TWO_BYTE_WORD_REPLACER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define TBWR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbwr: assertion failed");

// Next-cycle implication, off while reset is low.
`define TBWR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbwr: assertion failed");

// Next-cycle implication that also watches the reset cycles.
`define TBWR_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tbwr: assertion failed");

`endif

@@ src/tbwr_pkg.sv @@
package tbwr_pkg;

    localparam int MAX_ENTRIES   = 4;
    localparam int TABLE_ENTRIES = 4;
    localparam int WORD_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int REG_W         = 64;
    localparam int ADDR_W        = 6;
    localparam int QUEUE_DEPTH   = 2;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_SEARCH_WORDS  = 3'd0;
    localparam logic [2:0] REG_REPLACE_WORDS = 3'd1;
    localparam logic [2:0] REG_SEARCH_COUNT  = 3'd2;
    localparam logic [2:0] REG_REPLACE_COUNT = 3'd3;
    localparam logic [2:0] REG_ANY_POSITION  = 3'd4;
    localparam logic [2:0] REG_ALLOW_OVERLAP = 3'd5;

    typedef struct packed {
        logic [REG_W-1:0] search_words;
        logic [REG_W-1:0] replace_words;
        logic [2:0]       entries_used;  // saturated search count
        logic [2:0]       repl_last;     // index of last replacement word
        logic             repl_off;      // replace count of zero
        logic             any_position;
        logic             allow_overlap;
    } t_cfg;

    // One queued request from front to back: one or two results.
    typedef struct packed {
        logic [BYTE_W-1:0]      head_byte;
        logic [MAX_ENTRIES-1:0] cur_hits;
        logic [MAX_ENTRIES-1:0] prev_hits;
        logic                   head_last;
        logic                   tail_en;
        logic [BYTE_W-1:0]      tail_byte;
    } t_work;

endpackage

@@ src/tbwr_front.sv @@
module tbwr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tbwr_pkg::t_cfg             i_cfg,
    input  logic                       i_push,
    input  logic                       i_q_full,
    input  logic [tbwr_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_in_last,
    output logic                       o_q_push,
    output tbwr_pkg::t_work            o_work
);

    logic [tbwr_pkg::BYTE_W-1:0]      r_held_byte, n_held_byte;
    logic                             r_held_valid, n_held_valid;
    logic                             r_held_odd, n_held_odd;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] r_prior, n_prior;

    logic                             accept;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] used;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] prev_hits;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] cur_hits;
    logic [tbwr_pkg::WORD_W-1:0]      sword;
    logic                             match;

    assign accept = i_push && !i_q_full;

    // Compare the held byte and the new byte against every entry in use
    always_comb begin
        cur_hits = '0;
        used     = '0;
        sword    = '0;
        match    = 1'b0;
        for (int i = 0; i < tbwr_pkg::MAX_ENTRIES; i++) begin
            used[i] = 3'(i) < i_cfg.entries_used;
        end
        prev_hits = r_prior & used;
        for (int i = 0; i < tbwr_pkg::MAX_ENTRIES; i++) begin
            sword = i_cfg.search_words[tbwr_pkg::WORD_W*i +: tbwr_pkg::WORD_W];
            match = used[i] && (sword[7:0] == r_held_byte) && (sword[15:8] == i_in_byte);
            if (!i_cfg.any_position) begin
                cur_hits[i] = match && !r_held_odd;
            end else if (i_cfg.allow_overlap) begin
                cur_hits[i] = match;
            end else begin
                cur_hits[i] = match && !prev_hits[i];
            end
        end
    end

    always_comb begin
        o_q_push         = accept && (r_held_valid || i_in_last);
        o_work.head_byte = r_held_valid ? r_held_byte : i_in_byte;
        o_work.cur_hits  = r_held_valid ? cur_hits : '0;
        o_work.prev_hits = r_held_valid ? prev_hits : '0;
        o_work.head_last = !r_held_valid;
        o_work.tail_en   = r_held_valid && i_in_last;
        o_work.tail_byte = i_in_byte;
    end

    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_held_odd   = r_held_odd;
        n_prior      = r_prior;
        if (accept) begin
            if (i_in_last) begin
                n_held_byte  = '0;
                n_held_valid = 1'b0;
                n_held_odd   = 1'b0;
                n_prior      = '0;
            end else if (!r_held_valid) begin
                n_held_byte  = i_in_byte;
                n_held_valid = 1'b1;
                n_held_odd   = 1'b0;
                n_prior      = '0;
            end else begin
                n_held_byte  = i_in_byte;
                n_held_odd   = !r_held_odd;
                n_prior      = cur_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_held_odd   <= 1'b0;
            r_prior      <= '0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_held_odd   <= n_held_odd;
            r_prior      <= n_prior;
        end
    end

endmodule

@@ src/tbwr_queue.sv @@
module tbwr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tbwr_pkg::t_work i_work,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output tbwr_pkg::t_work o_work
);

    localparam int PTR_W = $clog2(tbwr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tbwr_pkg::QUEUE_DEPTH + 1);

    tbwr_pkg::t_work  r_slot [tbwr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(tbwr_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_work  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

    // Wrap the pointers at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == tbwr_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == tbwr_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

@@ src/tbwr_back.sv @@
module tbwr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tbwr_pkg::t_cfg              i_cfg,
    input  logic                        i_q_empty,
    input  tbwr_pkg::t_work             i_work,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [tbwr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last
);

    logic                             r_out_valid;
    logic [tbwr_pkg::BYTE_W-1:0]      r_out_byte, n_out_byte;
    logic                             r_out_last, n_out_last;
    logic                             r_tail_phase;
    logic                             out_free, advance;
    logic [tbwr_pkg::BYTE_W-1:0]      orig;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] hc, hp;
    logic [tbwr_pkg::WORD_W-1:0]      rword [tbwr_pkg::MAX_ENTRIES];
    logic [2:0]                       ridx;

    assign out_free = !r_out_valid || i_pop;
    assign advance  = out_free && !i_q_empty;
    // Drop the queue entry once its last result is loaded
    assign o_q_pop  = advance && (r_tail_phase || !i_work.tail_en);

    // Head result: hits at and before this byte; tail result: hits before it only
    always_comb begin
        orig = r_tail_phase ? i_work.tail_byte : i_work.head_byte;
        hc   = r_tail_phase ? '0 : i_work.cur_hits;
        hp   = r_tail_phase ? i_work.cur_hits : i_work.prev_hits;
        n_out_last = r_tail_phase ? 1'b1 : i_work.head_last;
        n_out_byte = orig;
        ridx = '0;
        for (int i = 0; i < tbwr_pkg::MAX_ENTRIES; i++) begin
            rword[i] = i_cfg.replace_words[tbwr_pkg::WORD_W*i +: tbwr_pkg::WORD_W];
        end
        // Higher entries override lower ones
        for (int i = 0; i < tbwr_pkg::MAX_ENTRIES; i++) begin
            ridx = (3'(i) < i_cfg.repl_last) ? 3'(i) : i_cfg.repl_last;
            if (!i_cfg.repl_off) begin
                if (hc[i]) begin
                    n_out_byte = rword[ridx[1:0]][7:0];
                end else if (hp[i]) begin
                    n_out_byte = rword[ridx[1:0]][15:8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_tail_phase <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_tail_phase <= !r_tail_phase && i_work.tail_en;
            end else if (i_pop) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

endmodule

@@ src/two_byte_word_replacer.sv @@
// Channel      | Handshake                 | Payload
// -------------+---------------------------+-------------------------
// input bytes  | push / full               | i_in_byte, i_in_last
// result bytes | pop / empty               | o_out_byte, o_out_last
// registers    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One byte request is taken per cycle while full is low. A request that yields
// two results (the final byte of a string) holds the back end until both are
// loaded; all others yield one. Results trail the input by one byte plus two register
// stages (request queue, result register). Synchronous active-low reset empties
// both queues and clears the held byte. Either side may stall on its own: the
// two-entry request queue sits between the matcher and the result register.
module two_byte_word_replacer #(
    parameter int P_TABLE_ENTRIES = tbwr_pkg::TABLE_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input byte stream
    input  logic                         push,
    output logic                         full,
    input  logic [tbwr_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                         i_in_last,
    // Result byte stream
    output logic                         empty,
    input  logic                         pop,
    output logic [tbwr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_out_last,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbwr_pkg::ADDR_W-1:0]  paddr,
    input  logic [tbwr_pkg::REG_W-1:0]   pwdata,
    output logic [tbwr_pkg::REG_W-1:0]   prdata,
    output logic                         pready
);

    localparam logic [2:0] TE = 3'(P_TABLE_ENTRIES);

    logic [tbwr_pkg::REG_W-1:0] r_search_words, r_replace_words;
    logic [2:0]                 r_search_count, r_replace_count;
    logic                       r_any_position, r_allow_overlap;
    logic [2:0]                 reg_idx;
    logic [2:0]                 rc_sat;
    logic                       wr_en;

    tbwr_pkg::t_cfg  cfg;
    tbwr_pkg::t_work fq_work, qb_work;
    logic            fq_push, q_full, q_empty, q_pop;

    // Register file: register i sits at byte address 8*i
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_words  <= '0;
            r_replace_words <= '0;
            r_search_count  <= 3'd1;
            r_replace_count <= 3'd1;
            r_any_position  <= 1'b0;
            r_allow_overlap <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                tbwr_pkg::REG_SEARCH_WORDS:  r_search_words  <= pwdata;
                tbwr_pkg::REG_REPLACE_WORDS: r_replace_words <= pwdata;
                tbwr_pkg::REG_SEARCH_COUNT:  r_search_count  <= pwdata[2:0];
                tbwr_pkg::REG_REPLACE_COUNT: r_replace_count <= pwdata[2:0];
                tbwr_pkg::REG_ANY_POSITION:  r_any_position  <= pwdata[0];
                tbwr_pkg::REG_ALLOW_OVERLAP: r_allow_overlap <= pwdata[0];
                default: ;  // unmapped address, drop the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tbwr_pkg::REG_SEARCH_WORDS:  prdata = r_search_words;
            tbwr_pkg::REG_REPLACE_WORDS: prdata = r_replace_words;
            tbwr_pkg::REG_SEARCH_COUNT:  prdata = {61'd0, r_search_count};
            tbwr_pkg::REG_REPLACE_COUNT: prdata = {61'd0, r_replace_count};
            tbwr_pkg::REG_ANY_POSITION:  prdata = {63'd0, r_any_position};
            tbwr_pkg::REG_ALLOW_OVERLAP: prdata = {63'd0, r_allow_overlap};
            default:                     prdata = '0;
        endcase
    end

    // Saturate both counts at the table size; a replace count of zero disables replacement
    assign rc_sat = (r_replace_count > TE) ? TE : r_replace_count;

    always_comb begin
        cfg.search_words  = r_search_words;
        cfg.replace_words = r_replace_words;
        cfg.entries_used  = (r_search_count > TE) ? TE : r_search_count;
        cfg.repl_last     = rc_sat - 3'd1;
        cfg.repl_off      = r_replace_count == 3'd0;
        cfg.any_position  = r_any_position;
        cfg.allow_overlap = r_allow_overlap;
    end

    assign full = q_full;

    // Front end: hold one byte, find the hits, post one request per result group
    tbwr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_push    (push),
        .i_q_full  (q_full),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_q_push  (fq_push),
        .o_work    (fq_work)
    );

    // Request queue between the two halves
    tbwr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_work  (fq_work),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_work  (qb_work)
    );

    // Back end: pick each output byte and hold it until taken
    tbwr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_empty  (q_empty),
        .i_work     (qb_work),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

@@ src/tbwr_checker.sv @@
`include "two_byte_word_replacer_macros.svh"

module tbwr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [tbwr_pkg::BYTE_W-1:0] o_out_byte,
    input  logic                        o_out_last
);

    // Reset leaves both queues empty
    `TBWR_ASSERT_NXT_ALL(a_reset_clears, i_clk, !i_rst_n, empty && !full)

    // A waiting result holds until taken
    `TBWR_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_byte) && $stable(o_out_last))

    // The request queue fills only on an input request
    `TBWR_ASSERT_NXT(a_full_needs_push, i_clk, i_rst_n, !full && !push, !full)

    // The queue becomes full only after an input request
    `TBWR_ASSERT_IMP(a_full_after_push, i_clk, i_rst_n, $rose(full), $past(push))

endmodule

bind two_byte_word_replacer tbwr_checker u_tbwr_checker (.*);

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Bound the run well above the slowest legal run: every string byte
    // waiting out a full sender gap plus two results behind full sink stalls.
    localparam int CYCLE_LIMIT      = 400_000;
    // Cycles to let pass after the last result, so a byte that only got held
    // has certainly landed inside the block before a register changes.
    localparam int DRAIN_CYCLES     = 8;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_BYTES      = 146;
    // Index beyond the register map; a write there must change nothing.
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic [tbwr_pkg::BYTE_W-1:0] value;
        logic                        last;
    } t_stream_byte;

    logic                          i_clk;
    logic                          i_rst_n   = 1'b0;
    logic                          push      = 1'b0;
    logic                          full;
    logic [tbwr_pkg::BYTE_W-1:0]   i_in_byte = '0;
    logic                          i_in_last = 1'b0;
    logic                          empty;
    logic                          pop       = 1'b0;
    logic [tbwr_pkg::BYTE_W-1:0]   o_out_byte;
    logic                          o_out_last;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [tbwr_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [tbwr_pkg::REG_W-1:0]    pwdata    = '0;
    logic [tbwr_pkg::REG_W-1:0]    prdata;
    logic                          pready;

    two_byte_word_replacer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Source bytes still to be sent, and result bytes still to arrive.
    t_stream_byte source_bytes[$];
    t_stream_byte expected_bytes[$];
    t_stream_byte next_req;

    // Shadow of the register file, starting from the reset values.
    logic [tbwr_pkg::REG_W-1:0] shadow_search        = '0;
    logic [tbwr_pkg::REG_W-1:0] shadow_replace       = '0;
    logic [2:0]                 shadow_search_count  = 3'd1;
    logic [2:0]                 shadow_replace_count = 3'd1;
    logic                       shadow_any_position  = 1'b0;
    logic                       shadow_allow_overlap = 1'b0;

    // Matcher state: the byte waiting for its successor and the hits that
    // started one position before it.
    logic [tbwr_pkg::BYTE_W-1:0]      held_byte  = '0;
    logic                             held_valid = 1'b0;
    logic                             held_odd   = 1'b0;
    logic [tbwr_pkg::MAX_ENTRIES-1:0] prior_hits = '0;

    logic req_taken  = 1'b0;
    logic idling     = 1'b1;
    int   send_gap   = 0;
    int   drain_gap  = 0;
    int   cycles     = 0;
    int   mismatches = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Counts above the table size saturate.
    function automatic int clamp_entries(input logic [2:0] count);
        return (count > tbwr_pkg::TABLE_ENTRIES) ? tbwr_pkg::TABLE_ENTRIES : int'(count);
    endfunction

    // Entries past the last replacement word share that last word.
    function automatic logic [tbwr_pkg::BYTE_W-1:0] replacement_byte(input int entry,
                                                                     input logic second);
        int                          last_word;
        logic [tbwr_pkg::WORD_W-1:0] word;
        last_word = clamp_entries(shadow_replace_count) - 1;
        word = shadow_replace[tbwr_pkg::WORD_W*((entry < last_word) ? entry : last_word)
                              +: tbwr_pkg::WORD_W];
        return second ? word[15:8] : word[7:0];
    endfunction

    // Highest entry wins a byte; for one entry the hit starting here beats
    // the hit that started one byte earlier.
    function automatic logic [tbwr_pkg::BYTE_W-1:0] resolve_byte(
        input logic [tbwr_pkg::BYTE_W-1:0]      orig,
        input logic [tbwr_pkg::MAX_ENTRIES-1:0] cur_hits,
        input logic [tbwr_pkg::MAX_ENTRIES-1:0] prev_hits);
        int i;
        if (shadow_replace_count == 3'd0) begin
            return orig;
        end
        for (i = clamp_entries(shadow_search_count) - 1; i >= 0; i--) begin
            if (cur_hits[i]) begin
                return replacement_byte(i, 1'b0);
            end
            if (prev_hits[i]) begin
                return replacement_byte(i, 1'b1);
            end
        end
        return orig;
    endfunction

    // Advance the matcher by one accepted request and queue the bytes it
    // releases: none, one, or two at the end of a string.
    task automatic predict_request(input logic [tbwr_pkg::BYTE_W-1:0] in_value,
                                   input logic in_last);
        int                               n;
        int                               i;
        logic [tbwr_pkg::MAX_ENTRIES-1:0] prev_hits;
        logic [tbwr_pkg::MAX_ENTRIES-1:0] cur_hits;
        logic [tbwr_pkg::WORD_W-1:0]      word;
        logic                             hit;
        t_stream_byte                     rec;
        n = clamp_entries(shadow_search_count);
        prev_hits = '0;
        cur_hits = '0;
        if (!held_valid) begin
            if (in_last) begin
                // single-byte string: pass it straight through
                rec = '{value: in_value, last: 1'b1};
                expected_bytes.push_back(rec);
            end else begin
                held_byte = in_value;
                held_valid = 1'b1;
                held_odd = 1'b0;
                prior_hits = '0;
            end
            return;
        end
        for (i = 0; i < n; i++) begin
            // drop stale hits of entries that went out of use
            prev_hits[i] = prior_hits[i];
            word = shadow_search[tbwr_pkg::WORD_W*i +: tbwr_pkg::WORD_W];
            hit = (word[7:0] == held_byte) && (word[15:8] == in_value);
            if (!shadow_any_position) begin
                cur_hits[i] = hit && !held_odd;
            end else if (shadow_allow_overlap) begin
                cur_hits[i] = hit;
            end else begin
                cur_hits[i] = hit && !prev_hits[i];
            end
        end
        rec = '{value: resolve_byte(held_byte, cur_hits, prev_hits), last: 1'b0};
        expected_bytes.push_back(rec);
        if (in_last) begin
            rec = '{value: resolve_byte(in_value, '0, cur_hits), last: 1'b1};
            expected_bytes.push_back(rec);
            held_byte = '0;
            held_valid = 1'b0;
            held_odd = 1'b0;
            prior_hits = '0;
        end else begin
            held_byte = in_value;
            held_odd = !held_odd;
            prior_hits = cur_hits;
        end
    endtask

    task automatic check_result(input logic [tbwr_pkg::BYTE_W-1:0] got_value,
                                input logic got_last);
        t_stream_byte want;
        if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
                $display("%0t: result byte %h last %b arrived with none expected",
                         $time, got_value, got_last);
            end
        end else begin
            want = expected_bytes.pop_front();
            if (got_value !== want.value || got_last !== want.last) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES) begin
                    $display("%0t: result byte %h last %b, expected byte %h last %b",
                             $time, got_value, got_last, want.value, want.last);
                end
            end
        end
    endtask

    // Register write: setup cycle, then access cycle until pready. Update the
    // shadow at the edge that commits the write.
    task automatic write_reg(input logic [2:0] index,
                             input logic [tbwr_pkg::REG_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            tbwr_pkg::REG_SEARCH_WORDS:  shadow_search = value;
            tbwr_pkg::REG_REPLACE_WORDS: shadow_replace = value;
            tbwr_pkg::REG_SEARCH_COUNT:  shadow_search_count = value[2:0];
            tbwr_pkg::REG_REPLACE_COUNT: shadow_replace_count = value[2:0];
            tbwr_pkg::REG_ANY_POSITION:  shadow_any_position = value[0];
            tbwr_pkg::REG_ALLOW_OVERLAP: shadow_allow_overlap = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // leave on a rising edge so the next bytes are queued away from the driver
        @(posedge i_clk);
    endtask

    function automatic void add_byte(input logic [tbwr_pkg::BYTE_W-1:0] value,
                                     input logic last);
        t_stream_byte rec;
        rec = '{value: value, last: last};
        source_bytes.push_back(rec);
    endfunction

    // Wait until every request is in and every result is out, then give a
    // held byte time to settle before the registers change.
    task automatic settle();
        while (source_bytes.size() != 0 || push || expected_bytes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Request driver: hold a request until it is taken, otherwise idle in
    // bursts or present the next queued byte.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else if (push && !req_taken) begin
            // hold the pending request
        end else if (send_gap > 0) begin
            push <= 1'b0;
            send_gap--;
        end else if (source_bytes.size() != 0 && idling && $urandom_range(0, 15) == 0) begin
            push <= 1'b0;
            send_gap = $urandom_range(0, 14);
        end else if (source_bytes.size() != 0) begin
            next_req = source_bytes.pop_front();
            push <= 1'b1;
            i_in_byte <= next_req.value;
            i_in_last <= next_req.last;
        end else begin
            push <= 1'b0;
        end
    end

    // Result sink: pop freely, with random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            drain_gap = 0;
        end else if (drain_gap > 0) begin
            pop <= 1'b0;
            drain_gap--;
        end else if (idling && $urandom_range(0, 11) == 0) begin
            pop <= 1'b0;
            drain_gap = $urandom_range(0, 14);
        end else begin
            pop <= 1'b1;
        end
    end

    // Monitor: check the popped result before predicting from the request
    // taken at the same edge.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            req_taken <= i_rst_n && push && !full;
            if (i_rst_n && pop && !empty) begin
                check_result(o_out_byte, o_out_last);
            end
            if (i_rst_n && push && !full) begin
                predict_request(i_in_byte, i_in_last);
            end
        end
    end

    initial begin
        int                          p;
        int                          k;
        int                          remaining;
        int                          str_len;
        logic [tbwr_pkg::BYTE_W-1:0] alphabet [3];
        logic [tbwr_pkg::BYTE_W-1:0] value;
        logic [tbwr_pkg::REG_W-1:0]  words;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: "AB", "BC", "AA" and the word 00 FF.
        write_reg(tbwr_pkg::REG_SEARCH_WORDS, 64'hFF00_4141_4342_4241);
        write_reg(tbwr_pkg::REG_REPLACE_WORDS, 64'h00FF_6E6D_7170_7978);
        write_reg(tbwr_pkg::REG_SEARCH_COUNT, 64'd4);
        write_reg(tbwr_pkg::REG_REPLACE_COUNT, 64'd4);
        write_reg(tbwr_pkg::REG_ANY_POSITION, 64'd0);
        write_reg(tbwr_pkg::REG_ALLOW_OVERLAP, 64'd0);
        // single-byte strings at both byte extremes
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // aligned hit covering the whole string
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b1);
        // odd-position hit is skipped, the even one after it counts
        add_byte(8'h78, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h43, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h41, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h41, 1'b1);
        settle();

        // any position, greedy: "AAAA" hits at 0 and 2 only
        write_reg(tbwr_pkg::REG_ANY_POSITION, 64'd1);
        for (k = 0; k < 4; k++) begin
            add_byte(8'h41, k == 3);
        end
        settle();

        // overlapping hits: every position counts, later or higher wins
        write_reg(tbwr_pkg::REG_ALLOW_OVERLAP, 64'd1);
        for (k = 0; k < 3; k++) begin
            add_byte(8'h41, k == 2);
        end
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h43, 1'b1);
        settle();

        // Random phases: walk the counts through 0..7, the mode bits through
        // every pairing, and words built from a small alphabet so hits are
        // frequent. A phase may stop inside a string, so the next settings
        // apply mid-string.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            idling = (p < RANDOM_PHASES - 2);
            for (k = 0; k < 3; k++) begin
                alphabet[k] = 8'($urandom);
            end
            for (k = 0; k < 8; k++) begin
                words[tbwr_pkg::BYTE_W*k +: tbwr_pkg::BYTE_W] = alphabet[$urandom_range(0, 2)];
            end
            if (p == 2) begin
                words = '1;
            end else if (p == 3) begin
                words = '0;
            end
            write_reg(tbwr_pkg::REG_SEARCH_WORDS, words);
            words = {$urandom, $urandom};
            if (p == 2) begin
                words = '0;
            end else if (p == 3) begin
                words = '1;
            end
            write_reg(tbwr_pkg::REG_REPLACE_WORDS, words);
            write_reg(tbwr_pkg::REG_SEARCH_COUNT,
                      64'((p < 8) ? p : $urandom_range(1, tbwr_pkg::TABLE_ENTRIES)));
            write_reg(tbwr_pkg::REG_REPLACE_COUNT,
                      64'((p < 8) ? (3 * p) % 8
                                  : $urandom_range(1, tbwr_pkg::TABLE_ENTRIES)));
            write_reg(tbwr_pkg::REG_ANY_POSITION, 64'(p[0]));
            write_reg(tbwr_pkg::REG_ALLOW_OVERLAP, 64'(p[1]));
            if (p == 0) begin
                write_reg(REG_UNUSED, '1);
            end
            remaining = PHASE_BYTES;
            while (remaining > 0) begin
                str_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                      : $urandom_range(1, 10);
                for (k = 0; k < str_len && remaining > 0; k++) begin
                    // mostly bytes of the table words, some noise
                    if ($urandom_range(0, 3) != 0) begin
                        value = shadow_search[tbwr_pkg::BYTE_W*$urandom_range(0, 7)
                                              +: tbwr_pkg::BYTE_W];
                    end else begin
                        value = 8'($urandom);
                    end
                    add_byte(value, k == str_len - 1);
                    remaining--;
                end
            end
            settle();
        end

        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
